// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define UVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define UVG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== src/uvg_pkg.sv =====
package uvg_pkg;

  localparam int unsigned WORD_BITS    = 16;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned ROOT_W       = 2 * WORD_BITS;
  localparam int unsigned PROD_W       = CORDIC_W + WORD_BITS;
  localparam int unsigned FRAC_BITS    = 30;
  // prep, cordic stages, fix-up, multiply, round
  localparam int unsigned LATENCY      = CORDIC_STEPS + 4;

  typedef logic signed [CORDIC_W-1:0] cword_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  localparam cword_t CORDIC_START = cword_t'(64'sd652032874);
  localparam cword_t QUARTER_TURN = cword_t'(64'sd1073741824);
  localparam cword_t HALF_TURN    = cword_t'(64'sd2147483648);

  // atan(2^-i) in 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic                        last;
    logic                        flip;
    logic signed [WORD_BITS-1:0] z;
  } info_t;

  typedef struct packed {
    logic  valid;
    info_t info;
  } side_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input prod_t v);
    prod_t hi;
    prod_t lo;
    hi = $signed({{(PROD_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
    lo = $signed({{(PROD_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}});
    if (v > hi) begin
      sat_word = hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_BITS-1:0];
    end else begin
      sat_word = v[WORD_BITS-1:0];
    end
  endfunction

endpackage

// ===== src/uvg_cordic.sv =====
module uvg_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uvg_pkg::side_t  side_i,
  input  uvg_pkg::cword_t ang_i,
  output uvg_pkg::side_t  side_o,
  output uvg_pkg::cword_t cx_o,
  output uvg_pkg::cword_t cy_o
);
  import uvg_pkg::*;

  cword_t x_s [CORDIC_STEPS+1];
  cword_t y_s [CORDIC_STEPS+1];
  cword_t a_s [CORDIC_STEPS+1];
  logic   v_s [CORDIC_STEPS+1];
  info_t  i_s [CORDIC_STEPS+1];

  assign x_s[0] = CORDIC_START;
  assign y_s[0] = '0;
  assign a_s[0] = ang_i;
  assign v_s[0] = side_i.valid;
  assign i_s[0] = side_i.info;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam cword_t Atan = cword_t'(ATAN_TURNS[k]);
    cword_t x_d, y_d, a_d;
    cword_t x_q, y_q, a_q;
    logic   valid_q;
    info_t  info_q;

    always_comb begin
      if (!a_s[k][CORDIC_W-1]) begin
        x_d = x_s[k] - (y_s[k] >>> k);
        y_d = y_s[k] + (x_s[k] >>> k);
        a_d = a_s[k] - Atan;
      end else begin
        x_d = x_s[k] + (y_s[k] >>> k);
        y_d = y_s[k] - (x_s[k] >>> k);
        a_d = a_s[k] + Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else begin
        valid_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      a_q    <= a_d;
      info_q <= i_s[k];
    end

    assign x_s[k+1] = x_q;
    assign y_s[k+1] = y_q;
    assign a_s[k+1] = a_q;
    assign v_s[k+1] = valid_q;
    assign i_s[k+1] = info_q;
  end

  assign cx_o         = x_s[CORDIC_STEPS];
  assign cy_o         = y_s[CORDIC_STEPS];
  assign side_o.valid = v_s[CORDIC_STEPS];
  assign side_o.info  = i_s[CORDIC_STEPS];

endmodule

// ===== src/uvg_root.sv =====
module uvg_root (
  input  logic                         clk_i,
  input  logic [uvg_pkg::ROOT_W-1:0]   v_i,
  output logic [uvg_pkg::WORD_BITS-1:0] root_o,
  output logic [uvg_pkg::WORD_BITS:0]   rem_o
);
  import uvg_pkg::*;

  // one result bit per stage, then pass-through to match the cordic depth
  logic [ROOT_W-1:0] res_s [CORDIC_STEPS+1];
  logic [ROOT_W-1:0] rem_s [CORDIC_STEPS+1];

  assign res_s[0] = '0;
  assign rem_s[0] = v_i;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic [ROOT_W-1:0] res_d, rem_d, res_q, rem_q;

    if (k < WORD_BITS) begin : g_digit
      localparam logic [ROOT_W-1:0] Bit = ROOT_W'(1) << (2 * (WORD_BITS - 1 - k));
      logic [ROOT_W-1:0] trial;
      always_comb begin
        trial = res_s[k] + Bit;
        if (rem_s[k] >= trial) begin
          rem_d = rem_s[k] - trial;
          res_d = (res_s[k] >> 1) + Bit;
        end else begin
          rem_d = rem_s[k];
          res_d = res_s[k] >> 1;
        end
      end
    end else begin : g_pass
      assign res_d = res_s[k];
      assign rem_d = rem_s[k];
    end

    always_ff @(posedge clk_i) begin
      res_q <= res_d;
      rem_q <= rem_d;
    end

    assign res_s[k+1] = res_q;
    assign rem_s[k+1] = rem_q;
  end

  assign root_o = res_s[CORDIC_STEPS][WORD_BITS-1:0];
  assign rem_o  = rem_s[CORDIC_STEPS][WORD_BITS:0];

endmodule

// ===== src/uvg_scale.sv =====
module uvg_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uvg_pkg::side_t                side_i,
  input  uvg_pkg::cword_t               cx_i,
  input  uvg_pkg::cword_t               cy_i,
  input  logic [uvg_pkg::WORD_BITS-1:0] root_i,
  input  logic [uvg_pkg::WORD_BITS:0]   rem_i,
  output logic                          done_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_x_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_y_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_z_o,
  output logic                          last_vector_o
);
  import uvg_pkg::*;

  localparam logic [WORD_BITS:0]   RMax = {2'b00, {(WORD_BITS-1){1'b1}}};
  localparam prod_t                RoundHalf = prod_t'(64'sd1 <<< (FRAC_BITS - 1));

  // fix-up: quadrant flip, radius rounding and saturation
  logic [WORD_BITS:0]   r_sum;
  logic [WORD_BITS-2:0] r_a_d, r_a_q;
  cword_t               cx_a_d, cy_a_d, cx_a_q, cy_a_q;
  logic                 valid_a_q;
  info_t                info_a_q;

  always_comb begin
    r_sum = {1'b0, root_i} + (WORD_BITS+1)'(rem_i > {1'b0, root_i});
    r_a_d = (r_sum > RMax) ? RMax[WORD_BITS-2:0] : r_sum[WORD_BITS-2:0];
    cx_a_d = side_i.info.flip ? -cx_i : cx_i;
    cy_a_d = side_i.info.flip ? -cy_i : cy_i;
  end

  // multiply
  prod_t prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic  valid_b_q;
  info_t info_b_q;

  assign prod_x_d = prod_t'($signed({1'b0, r_a_q})) * prod_t'(cx_a_q);
  assign prod_y_d = prod_t'($signed({1'b0, r_a_q})) * prod_t'(cy_a_q);

  // round to nearest, saturate
  prod_t rnd_x, rnd_y;
  logic signed [WORD_BITS-1:0] vec_x_d, vec_y_d, vec_x_q, vec_y_q, vec_z_q;
  logic done_q, last_q;

  always_comb begin
    rnd_x   = (prod_x_q + RoundHalf) >>> FRAC_BITS;
    rnd_y   = (prod_y_q + RoundHalf) >>> FRAC_BITS;
    vec_x_d = sat_word(rnd_x);
    vec_y_d = sat_word(rnd_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= side_i.valid;
      valid_b_q <= valid_a_q;
      done_q    <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_a_q    <= r_a_d;
    cx_a_q   <= cx_a_d;
    cy_a_q   <= cy_a_d;
    info_a_q <= side_i.info;
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    info_b_q <= info_a_q;
    vec_x_q  <= vec_x_d;
    vec_y_q  <= vec_y_d;
    vec_z_q  <= info_b_q.z;
    last_q   <= info_b_q.last;
  end

  assign done_o        = done_q;
  assign vec_x_o       = vec_x_q;
  assign vec_y_o       = vec_y_q;
  assign vec_z_o       = vec_z_q;
  assign last_vector_o = last_q;

endmodule

// ===== src/isotropic_unit_vector_gen_core.sv =====
// Isotropic unit vector generator.
// Input word: random_height_i, random_phase_i and last_request_i, taken at a
// rising edge with start high and busy low. busy is always low: the pipeline
// never stalls, so a new word may be presented every cycle.
// Result word: vec_x_o, vec_y_o, vec_z_o (signed Q1.15) and last_vector_o,
// valid for exactly one cycle while done_o is high. There is no back-pressure;
// the receiver must take each word in the cycle it appears.
// Path from accept to done_o: one prep stage with the z*z multiply and angle
// fold, 32 cordic stages with the radius root running alongside, one fix-up
// stage, one multiply stage, one round stage.
// Throughput: one vector per cycle; set by the one-step-per-stage cordic.
// Results come out in input order.
// Reset (rst_ni low, asynchronous) clears all valid bits, so no done_o is
// raised for words taken before or during reset.
module isotropic_unit_vector_gen_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [uvg_pkg::WORD_BITS-1:0]        random_height_i,
  input  logic [uvg_pkg::WORD_BITS-1:0]        random_phase_i,
  input  logic                                 last_request_i,
  output logic                                 done_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_x_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_y_o,
  output logic signed [uvg_pkg::WORD_BITS-1:0] vec_z_o,
  output logic                                 last_vector_o
);
  import uvg_pkg::*;

  localparam logic [ROOT_W-1:0] RootOne = ROOT_W'(1) << (2 * WORD_BITS - 2);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // prep stage
  logic signed [WORD_BITS-1:0] z_d;
  logic [WORD_BITS-1:0]        abs_z;
  logic [ROOT_W-1:0]           zz, v_d, v_q;
  logic [31:0]                 phase32;
  cword_t                      ang_raw, ang_d, ang_q;
  logic                        flip_d;
  logic                        valid_q;
  info_t                       info_q;

  always_comb begin
    z_d     = $signed({~random_height_i[WORD_BITS-1], random_height_i[WORD_BITS-2:0]});
    abs_z   = z_d[WORD_BITS-1] ? (~z_d + WORD_BITS'(1)) : z_d;
    zz      = ROOT_W'(abs_z) * ROOT_W'(abs_z);
    v_d     = RootOne - zz;
    phase32 = 32'(random_phase_i) << (32 - WORD_BITS);
    ang_raw = cword_t'($signed(phase32));
    priority if (ang_raw > QUARTER_TURN) begin
      ang_d  = ang_raw - HALF_TURN;
      flip_d = 1'b1;
    end else if (ang_raw < -QUARTER_TURN) begin
      ang_d  = ang_raw + HALF_TURN;
      flip_d = 1'b1;
    end else begin
      ang_d  = ang_raw;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    ang_q       <= ang_d;
    info_q.last <= last_request_i;
    info_q.flip <= flip_d;
    info_q.z    <= z_d;
  end

  side_t                side_pre, side_rot;
  cword_t               cx, cy;
  logic [WORD_BITS-1:0] root;
  logic [WORD_BITS:0]   rem;

  assign side_pre.valid = valid_q;
  assign side_pre.info  = info_q;

  uvg_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_pre),
    .ang_i  (ang_q),
    .side_o (side_rot),
    .cx_o   (cx),
    .cy_o   (cy)
  );

  uvg_root u_root (
    .clk_i  (clk_i),
    .v_i    (v_q),
    .root_o (root),
    .rem_o  (rem)
  );

  uvg_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_i        (side_rot),
    .cx_i          (cx),
    .cy_i          (cy),
    .root_i        (root),
    .rem_i         (rem),
    .done_o        (done_o),
    .vec_x_o       (vec_x_o),
    .vec_y_o       (vec_y_o),
    .vec_z_o       (vec_z_o),
    .last_vector_o (last_vector_o)
  );

endmodule

// ===== src/uvg_checker.sv =====
`include "assert_macros.svh"

module uvg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic [uvg_pkg::WORD_BITS-1:0]        random_height_i,
  input logic                                 last_request_i,
  input logic                                 done_o,
  input logic signed [uvg_pkg::WORD_BITS-1:0] vec_x_o,
  input logic signed [uvg_pkg::WORD_BITS-1:0] vec_y_o,
  input logic signed [uvg_pkg::WORD_BITS-1:0] vec_z_o,
  input logic                                 last_vector_o
);
  import uvg_pkg::*;

  localparam logic [WORD_BITS-1:0] ZFlip = WORD_BITS'(1) << (WORD_BITS - 1);

  logic                        accept;
  logic signed [WORD_BITS-1:0] z_word;
  logic                        pole_word;
  logic                        origin;

  assign accept    = start && !busy;
  assign z_word    = $signed(random_height_i ^ ZFlip);
  assign pole_word = (random_height_i == '0);
  assign origin    = (vec_x_o == '0) && (vec_y_o == '0);

  `UVG_ASSERT(a_word_out, accept |-> ##LATENCY done_o, "accepted word lost")
  `UVG_ASSERT_NEVER(a_no_extra, done_o && !$past(accept, LATENCY), "spurious done")
  `UVG_ASSERT(a_z_copy, done_o |-> (vec_z_o == $past(z_word, LATENCY)), "z mismatch")
  `UVG_ASSERT(a_last_copy, done_o |-> (last_vector_o == $past(last_request_i, LATENCY)), "bad last")
  `UVG_ASSERT(a_pole, (done_o && $past(pole_word, LATENCY)) |-> origin, "pole not at origin")

endmodule

bind isotropic_unit_vector_gen_core uvg_checker u_checker (.*);
